// ===== src/srsw_pkg.sv =====
package srsw_pkg;

    // Sizing of the transfer and of the send window
    localparam int MAX_PACKETS  = 256;
    localparam int MAX_WINDOW   = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int WIN_MAX      = (MAX_WINDOW < RESULT_LIMIT) ? MAX_WINDOW : RESULT_LIMIT;

    // Field widths fixed by the port format
    localparam int SEQ_W       = 8;
    localparam int ACT_W       = 2;
    localparam int CFG_CNT_W   = 9;
    localparam int CFG_WIN_W   = 5;
    localparam int CFG_DATA_W  = 9;

    // Internal widths derived from the sizing
    localparam int CNT_W = $clog2(MAX_PACKETS) + 1;
    localparam int CMP_W = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;
    localparam int KEY_W = (CNT_W > SEQ_W) ? CNT_W : SEQ_W;
    localparam int WIN_W = $clog2(WIN_MAX + 1);
    localparam int WCMP_W = ((WIN_W > CFG_WIN_W) ? WIN_W : CFG_WIN_W) + 1;
    localparam int OFF_W = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;

    // Event kinds
    typedef enum logic [ACT_W-1:0] {
        ACT_START   = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_NACK    = 2'd2,
        ACT_TIMEOUT = 2'd3
    } action_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_PACKET_COUNT = 1'b0,
        CFG_WINDOW_SIZE  = 1'b1
    } cfg_index_t;

    // Effective (clamped) configuration handed to the sequencer
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [WIN_W-1:0] window;
    } cfg_t;

    // One send request from the sequencer to the output register
    typedef struct packed {
        logic             valid;
        logic [SEQ_W-1:0] seq;
        logic             resend;
        logic             last;
        logic             all_done;
    } emit_t;

endpackage

// ===== src/srsw_seq.sv =====
module srsw_seq
    import srsw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  action_t          in_action,
    input  logic [SEQ_W-1:0] in_seq,
    input  cfg_t             cfg,
    input  logic             out_free,
    output logic             idle,
    output emit_t            emit
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_START   = 6'b000010,
        ST_TIMEOUT = 6'b000100,
        ST_SLIDE   = 6'b001000,
        ST_NACK    = 6'b010000,
        ST_NEW     = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    base_reg, base_next;
    logic [CNT_W-1:0]    next_reg, next_next;
    logic [CNT_W-1:0]    walk_reg, walk_next;
    logic [WIN_MAX-1:0]  amap_reg, amap_next;
    logic [WIN_MAX-1:0]  live_reg, live_next;
    logic [SEQ_W-1:0]    k_reg, k_next;
    logic                nack_reg, nack_next;

    logic [CNT_W:0]      lim;
    logic [CNT_W-1:0]    next_inc;
    logic [CNT_W-1:0]    span;
    logic                may_send;
    logic                may_after;
    logic                done;
    logic [KEY_W-1:0]    k_ext;
    logic [KEY_W-1:0]    base_ext;
    logic [KEY_W-1:0]    next_ext;
    logic [KEY_W-1:0]    k_off;
    logic                in_window;
    logic [WIN_MAX-1:0]  live_init;

    // Window limit and the gate on a new send, now and after one more send
    always_comb
    begin
        lim       = {1'b0, base_reg} + (CNT_W + 1)'(cfg.window);
        next_inc  = next_reg + 1'b1;
        may_send  = (next_reg < cfg.count) && ({1'b0, next_reg} < lim);
        may_after = (next_inc < cfg.count) && ({1'b0, next_inc} < lim);
        done      = (base_reg >= cfg.count);
        span      = next_reg - base_reg;
    end

    // Locate an ack or nack number inside the outstanding window
    always_comb
    begin
        k_ext     = KEY_W'(in_seq);
        base_ext  = KEY_W'(base_reg);
        next_ext  = KEY_W'(next_reg);
        in_window = (k_ext >= base_ext) && (k_ext < next_ext);
        k_off     = k_ext - base_ext;
    end

    // Unacknowledged outstanding entries, relative to the base
    always_comb
    begin
        for (int i = 0; i < WIN_MAX; i++)
        begin
            live_init[i] = (i < int'(span)) && !amap_reg[i];
        end
    end

    // Sequencer: one walk, slide or send step per cycle, send if out_free
    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        next_next  = next_reg;
        walk_next  = walk_reg;
        amap_next  = amap_reg;
        live_next  = live_reg;
        k_next     = k_reg;
        nack_next  = nack_reg;
        emit       = '0;
        emit.all_done = done;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_action)
                        ACT_START:
                        begin
                            amap_next  = '0;
                            base_next  = '0;
                            next_next  = '0;
                            state_next = ST_START;
                        end
                        ACT_TIMEOUT:
                        begin
                            live_next  = live_init;
                            walk_next  = base_reg;
                            state_next = ST_TIMEOUT;
                        end
                        ACT_ACK, ACT_NACK:
                        begin
                            if (in_window && (in_action == ACT_ACK))
                            begin
                                amap_next[k_off[OFF_W-1:0]] = 1'b1;
                            end
                            nack_next  = in_window && (in_action == ACT_NACK);
                            k_next     = in_seq;
                            state_next = ST_SLIDE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_START:
            begin
                if (!may_send)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit.valid  = 1'b1;
                    emit.seq    = SEQ_W'(next_reg);
                    emit.resend = 1'b0;
                    emit.last   = !may_after;
                    next_next   = next_inc;
                    if (!may_after)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_TIMEOUT:
            begin
                if (live_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (!live_reg[0])
                begin
                    live_next = live_reg >> 1;
                    walk_next = walk_reg + 1'b1;
                end
                else if (out_free)
                begin
                    emit.valid  = 1'b1;
                    emit.seq    = SEQ_W'(walk_reg);
                    emit.resend = 1'b1;
                    emit.last   = ((live_reg >> 1) == '0);
                    live_next   = live_reg >> 1;
                    walk_next   = walk_reg + 1'b1;
                    if ((live_reg >> 1) == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SLIDE:
            begin
                if ((base_reg < cfg.count) && amap_reg[0])
                begin
                    amap_next = amap_reg >> 1;
                    base_next = base_reg + 1'b1;
                end
                else
                begin
                    state_next = nack_reg ? ST_NACK : ST_NEW;
                end
            end

            ST_NACK:
            begin
                if (out_free)
                begin
                    emit.valid  = 1'b1;
                    emit.seq    = k_reg;
                    emit.resend = 1'b1;
                    emit.last   = !may_send;
                    state_next  = may_send ? ST_NEW : ST_IDLE;
                end
            end

            ST_NEW:
            begin
                if (!may_send)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit.valid  = 1'b1;
                    emit.seq    = SEQ_W'(next_reg);
                    emit.resend = 1'b0;
                    emit.last   = 1'b1;
                    next_next   = next_inc;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

    // Hold window state; reset clears it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            base_reg  <= '0;
            next_reg  <= '0;
            walk_reg  <= '0;
            amap_reg  <= '0;
            live_reg  <= '0;
            nack_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            next_reg  <= next_next;
            walk_reg  <= walk_next;
            amap_reg  <= amap_next;
            live_reg  <= live_next;
            nack_reg  <= nack_next;
        end
    end

    // Hold the ack or nack number of the current event
    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
    end

    // Outstanding span never exceeds the largest window size
    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        (next_reg >= base_reg) && (int'(next_reg - base_reg) <= WIN_MAX))
        else $error("outstanding span out of window");

    // Send requests only when the output register can take them
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> out_free)
        else $error("send request while output stalled");

    // No send request while waiting for an event
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        idle |-> !emit.valid)
        else $error("send request while idle");

    // A start leaves an empty window behind it
    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (idle && in_valid && (in_action == ACT_START)) |=> (base_reg == '0) && (amap_reg == '0))
        else $error("start did not clear the window");

endmodule

// ===== src/selective_repeat_sender_window_core.sv =====
// An accepted start puts the sequencer in its start state, which loads the first window into
//   the output register; a timeout steps past acknowledged entries as it resends, and an ack or
//   nack first slides the base past acknowledged packets. Events are taken only while idle; a
//   start or timeout walks the window, one entry per cycle while the output is not stalled.
// Reset: window base, next-to-send and all acknowledged marks clear; packet
//   count returns to 5 and window size to 2.
module selective_repeat_sender_window_core
    import srsw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SEQ_W-1:0]      s_tdata,   // [7:0] seq_number
    input  logic [ACT_W-1:0]      s_tuser,   // [1:0] action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SEQ_W-1:0]      m_tdata,   // [7:0] send_seq
    output logic [1:0]            m_tuser,   // [0] resend, [1] all_done
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_CNT_W-1:0] pcount_reg;
    logic [CFG_WIN_W-1:0] wsize_reg;
    logic                 m_valid_reg;
    logic [SEQ_W-1:0]     m_seq_reg;
    logic                 m_resend_reg;
    logic                 m_last_reg;
    logic                 m_done_reg;

    cfg_t                 cfg;
    emit_t                emit;
    logic                 idle;
    logic                 out_free;
    logic                 in_accept;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= CFG_CNT_W'(5);
            wsize_reg  <= CFG_WIN_W'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_PACKET_COUNT)
            begin
                pcount_reg <= cfg_data[CFG_CNT_W-1:0];
            end
            else
            begin
                wsize_reg <= cfg_data[CFG_WIN_W-1:0];
            end
        end
    end

    // Clamp packet count and window to what the window logic supports
    always_comb
    begin
        if (CMP_W'(pcount_reg) > CMP_W'(MAX_PACKETS))
        begin
            cfg.count = CNT_W'(MAX_PACKETS);
        end
        else
        begin
            cfg.count = CNT_W'(pcount_reg);
        end

        if (wsize_reg == '0)
        begin
            cfg.window = WIN_W'(1);
        end
        else if (WCMP_W'(wsize_reg) > WCMP_W'(WIN_MAX))
        begin
            cfg.window = WIN_W'(WIN_MAX);
        end
        else
        begin
            cfg.window = WIN_W'(wsize_reg);
        end
    end

    // Event request side
    assign s_tready  = idle;
    assign in_accept = s_tvalid && s_tready;

    srsw_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_accept),
        .in_action (action_t'(s_tuser)),
        .in_seq    (s_tdata),
        .cfg       (cfg),
        .out_free  (out_free),
        .idle      (idle),
        .emit      (emit)
    );

    // Output register: load a send request, drop it once taken
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            m_seq_reg    <= emit.seq;
            m_resend_reg <= emit.resend;
            m_last_reg   <= emit.last;
            m_done_reg   <= emit.all_done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_seq_reg;
    assign m_tuser  = {m_done_reg, m_resend_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ===== tb/selective_repeat_sender_window_core_tb.sv =====
module selective_repeat_sender_window_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srsw_pkg::*;

    localparam int SETTLE_CYCLES  = 40;
    localparam int ITEMS_PER_MODE = 40;
    localparam int CHECKED        = 0;
    localparam int LOOKAHEAD      = 1;

    typedef struct packed {
        action_t          act;
        logic [SEQ_W-1:0] seq;
    } arq_req_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic             resend;
        logic             last;
        logic             all_done;
    } send_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SEQ_W-1:0]      s_tdata   = '0;
    logic [ACT_W-1:0]      s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SEQ_W-1:0]      m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Window state: one copy checks the block, the other steers the stimulus
    logic [CFG_CNT_W-1:0] pkt_count = 9'd5;
    logic [CFG_WIN_W-1:0] win_size  = 5'd2;
    bit                   acked_mark [2][MAX_PACKETS];
    bit [CNT_W-1:0]       base_idx [2];
    bit [CNT_W-1:0]       next_idx [2];

    arq_req_t arq_events [$];
    send_t    due_sends [$];
    arq_req_t offered;
    send_t    seen;
    send_t    wanted;
    int       queued_items  = 0;
    int       fault_count   = 0;
    int       send_idle_pct = 29;
    int       recv_idle_pct = 65;
    int       hold_left     = 0;

    selective_repeat_sender_window_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] seq_number
        .s_tuser   (s_tuser),   // [1:0] action
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [7:0] send_seq
        .m_tuser   (m_tuser),   // [0] resend, [1] all_done
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one request to a copy of the window; the checked copy queues its sends
    function automatic int advance_window(int cp, action_t act, logic [SEQ_W-1:0] k);
        int unsigned cnt;
        int unsigned win;
        int unsigned b;
        int unsigned nx;
        int unsigned j;
        int          n;
        send_t       sends [RESULT_LIMIT];
        cnt = (pkt_count > MAX_PACKETS) ? MAX_PACKETS : pkt_count;
        win = win_size;
        if (win < 1)
            win = 1;
        if (win > WIN_MAX)
            win = WIN_MAX;
        b  = base_idx[cp];
        nx = next_idx[cp];
        n  = 0;
        case (act)
            ACT_START:
            begin
                // clear the transfer and send the first window
                for (j = 0; j < MAX_PACKETS; j++)
                    acked_mark[cp][j] = 1'b0;
                b  = 0;
                nx = 0;
                while (n < RESULT_LIMIT && nx < cnt && nx < b + win)
                begin
                    sends[n] = {SEQ_W'(nx), 1'b0, 2'b00};
                    n++;
                    nx++;
                end
            end
            ACT_TIMEOUT:
            begin
                // resend every unacknowledged packet, walking at most 16 entries
                for (j = b; j < nx && j < b + RESULT_LIMIT; j++)
                begin
                    if (!acked_mark[cp][j])
                    begin
                        sends[n] = {SEQ_W'(j), 1'b1, 2'b00};
                        n++;
                    end
                end
            end
            default:
            begin
                // numbers outside the window mark nothing and resend nothing
                if (k >= b && k < nx)
                begin
                    if (act == ACT_ACK)
                        acked_mark[cp][k] = 1'b1;
                    else
                    begin
                        sends[n] = {k, 1'b1, 2'b00};
                        n++;
                    end
                end
                // slide the base, then send one new packet if allowed
                while (b < cnt && acked_mark[cp][b])
                    b++;
                if (nx < cnt && nx < b + win)
                begin
                    sends[n] = {SEQ_W'(nx), 1'b0, 2'b00};
                    n++;
                    nx++;
                end
            end
        endcase
        base_idx[cp] = CNT_W'(b);
        next_idx[cp] = CNT_W'(nx);
        for (j = 0; j < n; j++)
        begin
            sends[j].all_done = (b >= cnt);
            sends[j].last     = (j == n - 1);
            if (cp == CHECKED)
                due_sends.push_back(sends[j]);
        end
        return n;
    endfunction

    function automatic void queue_event(action_t act, logic [SEQ_W-1:0] k);
        arq_events.push_back({act, k});
        void'(advance_window(LOOKAHEAD, act, k));
        queued_items++;
    endfunction

    function automatic void note_fault(string what);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t ns: %s", $time, what);
    endfunction

    // Driver: offer requests, predicting the sends of each one taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                void'(advance_window(CHECKED, offered.act, offered.seq));
            if (!s_tvalid || s_tready)
            begin
                if (arq_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = arq_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= offered.seq;
                    s_tuser  <= offered.act;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: hold off for a counted stretch when asked, else stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: compare each send with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = {m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
            if (due_sends.size() == 0)
                note_fault($sformatf("unexpected send: seq %0d resend %0b last %0b done %0b",
                                     seen.seq, seen.resend, seen.last, seen.all_done));
            else
            begin
                wanted = due_sends.pop_front();
                if (seen !== wanted)
                    note_fault($sformatf({"send mismatch: expected seq %0d resend %0b ",
                                          "last %0b done %0b, got seq %0d resend %0b ",
                                          "last %0b done %0b"},
                                         wanted.seq, wanted.resend, wanted.last,
                                         wanted.all_done, seen.seq, seen.resend,
                                         seen.last, seen.all_done));
            end
        end
    end

    // Wait until every request is taken and every send has arrived, then settle
    task automatic drain();
        do
            @(negedge clk);
        while (arq_events.size() != 0 || s_tvalid || due_sends.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PACKET_COUNT: pkt_count = val[CFG_CNT_W-1:0];
            default:          win_size  = val[CFG_WIN_W-1:0];
        endcase
    endtask

    task automatic set_config(logic [CFG_CNT_W-1:0] count, logic [CFG_WIN_W-1:0] win);
        drain();
        write_reg(CFG_PACKET_COUNT, CFG_DATA_W'(count));
        write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(win));
        @(negedge clk);
    endtask

    // One transfer: mostly acks and nacks inside the window, some timeouts and noise
    task automatic run_transfer(int max_events);
        int unsigned cnt;
        int unsigned b;
        int unsigned nx;
        int unsigned r;
        int          i;
        queue_event(ACT_START, SEQ_W'($urandom));
        cnt = (pkt_count > MAX_PACKETS) ? MAX_PACKETS : pkt_count;
        for (i = 0; i < max_events && base_idx[LOOKAHEAD] < cnt; i++)
        begin
            b  = base_idx[LOOKAHEAD];
            nx = next_idx[LOOKAHEAD];
            r  = $urandom_range(99);
            if (nx > b && r < 62)
                queue_event(ACT_ACK, SEQ_W'((r < 35) ? b : b + $urandom_range(nx - b - 1)));
            else if (nx > b && r < 74)
                queue_event(ACT_NACK, SEQ_W'(b + $urandom_range(nx - b - 1)));
            else if (r < 86)
                queue_event(ACT_TIMEOUT, SEQ_W'($urandom));
            else
                queue_event(action_t'($urandom_range(3)), SEQ_W'($urandom));
        end
    endtask

    task automatic random_mode(int budget);
        int                   first;
        logic [CFG_CNT_W-1:0] count;
        logic [CFG_WIN_W-1:0] win;
        first = queued_items;
        while (queued_items - first < budget)
        begin
            // mostly short transfers, now and then an extreme setting
            if ($urandom_range(99) < 80)
                count = CFG_CNT_W'($urandom_range(1, 24));
            else
                case ($urandom_range(4))
                    0:       count = 9'd0;
                    1:       count = 9'd256;
                    2:       count = 9'd300;
                    3:       count = 9'd511;
                    default: count = 9'd1;
                endcase
            if ($urandom_range(99) < 70)
                win = CFG_WIN_W'($urandom_range(1, 16));
            else
                case ($urandom_range(3))
                    0:       win = 5'd0;
                    1:       win = 5'd17;
                    2:       win = 5'd31;
                    default: win = 5'd16;
                endcase
            set_config(count, win);
            run_transfer(40);
        end
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: events before any start, nack of an acked packet,
        // numbers outside the window, and events after the transfer is done
        queue_event(ACT_TIMEOUT, 8'd0);
        queue_event(ACT_NACK, 8'd3);
        queue_event(ACT_START, 8'hA5);
        queue_event(ACT_ACK, 8'd1);
        queue_event(ACT_NACK, 8'd1);
        queue_event(ACT_TIMEOUT, 8'd0);
        queue_event(ACT_ACK, 8'd9);
        queue_event(ACT_ACK, 8'd0);
        queue_event(ACT_ACK, 8'd2);
        queue_event(ACT_ACK, 8'd3);
        queue_event(ACT_ACK, 8'd4);
        queue_event(ACT_ACK, 8'd4);
        queue_event(ACT_TIMEOUT, 8'd0);

        // Zero count and zero window: nothing to send
        set_config(9'd0, 5'd0);
        queue_event(ACT_START, 8'd0);
        queue_event(ACT_TIMEOUT, 8'd0);

        // Count and window above their caps: full window and full timeout walk
        set_config(9'd511, 5'd31);
        queue_event(ACT_START, 8'hFF);
        queue_event(ACT_NACK, 8'd255);
        queue_event(ACT_TIMEOUT, 8'd0);
        queue_event(ACT_ACK, 8'd0);

        // Shrink the settings in the middle of the transfer
        set_config(9'd3, 5'd1);
        queue_event(ACT_ACK, 8'd1);
        queue_event(ACT_ACK, 8'd2);
        set_config(9'd1, 5'd17);
        queue_event(ACT_TIMEOUT, 8'd0);
        queue_event(ACT_ACK, 8'd5);

        random_mode(ITEMS_PER_MODE);

        // Swap the idling of the two sides
        drain();
        send_idle_pct = 65;
        recv_idle_pct = 29;
        random_mode(ITEMS_PER_MODE);

        // No idling; hold the receiver off long enough to back up the input
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(9'd48, 5'd16);
        hold_left = 300;
        queue_event(ACT_START, 8'd0);
        repeat (4) queue_event(ACT_TIMEOUT, 8'd0);
        run_transfer(30);
        random_mode(ITEMS_PER_MODE);

        drain();
        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
